// File: design/allocation_bitmap_engine_top_assert.svh
// Assertion macros for the allocation bitmap engine.
// Expects the including module to provide clk and rst.
`ifndef ALLOCATION_BITMAP_ENGINE_TOP_ASSERT_SVH
`define ALLOCATION_BITMAP_ENGINE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define ABE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);
// Check a property on every clock edge, reset included.
`define ABE_ASSERT_NORST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);
`else
`define ABE_ASSERT(lbl, prop, msg)
`define ABE_ASSERT_NORST(lbl, prop, msg)
`endif
`endif

// File: design/abe_pkg.sv
// Shared types and constants of the allocation bitmap engine.
// No dependencies; used by abe_scan and the top module.
`default_nettype none
package abe_pkg;

  localparam int MAX_WORDS = 256;
  localparam int WORD_BITS = 32;
  localparam int ADDR_W    = $clog2(MAX_WORDS);
  localparam int IDX_W     = $clog2(WORD_BITS);
  localparam int BIT_W     = 13;
  localparam int RUN_W     = 14;
  localparam int CNT_W     = 13;
  localparam int CFG_W     = 9;
  localparam int ACT_W     = 4;
  localparam int STAT_W    = 2;
  localparam int CFG_RESET = 256;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_SET_BIT   = 4'd0,
    ACT_CLR_BIT   = 4'd1,
    ACT_SET_RANGE = 4'd2,
    ACT_CLR_RANGE = 4'd3,
    ACT_TEST      = 4'd4,
    ACT_FIND_CLR  = 4'd5,
    ACT_FIND_SET  = 4'd6,
    ACT_RUN_CLR   = 4'd7,
    ACT_RUN_SET   = 4'd8
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // Result of scanning one word for a run of matching bits
  typedef struct packed {
    logic             hit;        // run completes inside this word
    logic [IDX_W-1:0] hit_idx;    // bit at which the run completes
    logic             hit_cont;   // run at hit_idx continues the carried run
    logic             all_ones;   // every bit of the word matches
    logic [IDX_W-1:0] tail_ones;  // matching bits at the top of the word
  } scan_t;

endpackage
`default_nettype wire

// File: design/abe_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module abe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: design/abe_scan.sv
// Word scanner: finds where a run of matching bits reaches the wanted length.
// Depends on abe_pkg.
`default_nettype none
module abe_scan (
  input  wire logic [abe_pkg::WORD_BITS-1:0] match_bits,
  input  wire logic [abe_pkg::RUN_W-1:0]     need,
  input  wire logic [abe_pkg::CNT_W-1:0]     carry,
  output abe_pkg::scan_t                     res
);

  localparam int WB = abe_pkg::WORD_BITS;
  localparam int IW = abe_pkg::IDX_W;
  localparam int SW = abe_pkg::RUN_W + 1;

  logic [WB-1:0] pre;
  logic [WB-1:0] hitv;
  logic [IW:0]   need_lo;
  logic [IW:0]   shamt;
  logic [WB:0]   ones_ext;
  logic [WB-1:0] len_mask;
  logic          len_ok;
  logic          win_ok;
  logic          carry_ok;

  // Build per-bit hit flags: run length ending at each bit reaches need
  always_comb begin
    need_lo  = need[IW:0];
    ones_ext = ((WB+1)'(1) << need_lo) - (WB+1)'(1);
    len_mask = ones_ext[WB-1:0];
    pre[0]   = match_bits[0];
    for (int i = 1; i < WB; i++) begin
      pre[i] = pre[i-1] & match_bits[i];
    end
    shamt    = '0;
    len_ok   = 1'b0;
    win_ok   = 1'b0;
    carry_ok = 1'b0;
    for (int j = 0; j < WB; j++) begin
      len_ok   = (need <= abe_pkg::RUN_W'(j + 1));
      shamt    = (IW+1)'(j + 1) - need_lo;
      win_ok   = len_ok && (((match_bits >> shamt) & len_mask) == len_mask);
      carry_ok = ((SW'(carry) + SW'(j + 1)) >= SW'(need));
      hitv[j]  = pre[j] ? carry_ok : win_ok;
    end
  end

  // Pick the lowest hit and measure the matching tail of the word
  always_comb begin
    res.hit       = 1'b0;
    res.hit_idx   = '0;
    res.hit_cont  = 1'b0;
    res.all_ones  = pre[WB-1];
    res.tail_ones = '0;
    for (int j = WB - 1; j >= 0; j--) begin
      if (hitv[j]) begin
        res.hit      = 1'b1;
        res.hit_idx  = IW'(j);
        res.hit_cont = pre[j];
      end
    end
    for (int i = 0; i < WB; i++) begin
      if (!match_bits[i]) begin
        res.tail_ones = IW'(WB - 1 - i);
      end
    end
  end

endmodule
`default_nettype wire

// File: design/allocation_bitmap_engine_top.sv
// Allocation bitmap engine: bit store of 32-bit words in one RAM (abe_ram, abe_scan, abe_pkg).
// Bad index, empty range, zero run or unknown action are answered in idle, done in the next cycle.
// Bit ops act in exec. Range and search walk one word per cycle from first to last, or to a hit.
// Throughput: busy holds start off while walking; the next transaction is taken in the done cycle.
// Reset sets active_words to 256 and clears the per-word valid flags, so unwritten words read 0.
// Results show for one cycle on done; the receiver cannot stall.
`default_nettype none
`include "allocation_bitmap_engine_top_assert.svh"
module allocation_bitmap_engine_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [abe_pkg::ACT_W-1:0]   action,
  input  wire logic [abe_pkg::BIT_W-1:0]   first_bit,
  input  wire logic [abe_pkg::BIT_W-1:0]   last_bit,
  input  wire logic [abe_pkg::RUN_W-1:0]   run_length,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [abe_pkg::CFG_W-1:0]   cfg_data,
  output logic                             done,
  output logic [abe_pkg::STAT_W-1:0]       status,
  output logic                             bit_value,
  output logic [abe_pkg::BIT_W-1:0]        position
);

  localparam int WB = abe_pkg::WORD_BITS;
  localparam int IW = abe_pkg::IDX_W;
  localparam int AW = abe_pkg::ADDR_W;
  localparam int BW = abe_pkg::BIT_W;

  abe_pkg::state_t  state;
  abe_pkg::state_t  state_next;
  abe_pkg::action_t act_in;
  abe_pkg::action_t op;

  logic [abe_pkg::CFG_W-1:0] active_words;
  logic [abe_pkg::CFG_W-1:0] eff_words;
  logic [abe_pkg::MAX_WORDS-1:0] valid_bits;

  logic [BW-1:0]             first_q;
  logic [BW-1:0]             last_q;
  logic [abe_pkg::RUN_W-1:0] need_q;
  logic [AW-1:0]             addr;
  logic [AW-1:0]             last_word;
  logic [abe_pkg::CNT_W-1:0] cnt;
  logic [abe_pkg::CNT_W-1:0] cnt_next;
  logic [BW-1:0]             start_pos;
  logic [BW-1:0]             start_pos_next;
  logic                      vld_rd;

  logic                      accept;
  logic                      first_bad;
  logic                      last_bad;
  logic                      go_exec;
  logic                      finish;
  logic                      adv;
  logic                      carry_upd;
  logic                      res_load;
  abe_pkg::status_t          res_status;
  logic                      res_bit;
  logic [BW-1:0]             res_pos;

  logic                      ram_we;
  logic                      ram_re;
  logic [AW-1:0]             ram_raddr;
  logic [AW-1:0]             ram_waddr;
  abe_pkg::word_t            ram_wdata;
  abe_pkg::word_t            ram_rdata;

  abe_pkg::word_t            data;
  abe_pkg::word_t            bit_mask;
  abe_pkg::word_t            range_mask;
  abe_pkg::word_t            match_bits;
  logic [IW-1:0]             lo_idx;
  logic [IW-1:0]             hi_idx;
  logic                      want;
  logic [IW:0]               hit_off_ext;
  logic [IW-1:0]             tail_off;
  abe_pkg::scan_t            scan_res;

  // Word store and scanner
  abe_ram #(
    .WIDTH(WB),
    .DEPTH(abe_pkg::MAX_WORDS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  abe_scan u_scan (
    .match_bits(match_bits),
    .need      (need_q),
    .carry     (cnt),
    .res       (scan_res)
  );

  // Handshakes and effective word count
  assign busy      = (state != abe_pkg::S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign act_in    = abe_pkg::action_t'(action);
  assign ram_waddr = addr;

  always_comb begin
    if (active_words == '0) begin
      eff_words = abe_pkg::CFG_W'(1);
    end else if (active_words > abe_pkg::CFG_W'(abe_pkg::MAX_WORDS)) begin
      eff_words = abe_pkg::CFG_W'(abe_pkg::MAX_WORDS);
    end else begin
      eff_words = active_words;
    end
    first_bad = abe_pkg::CFG_W'(first_bit[BW-1:IW]) >= eff_words;
    last_bad  = abe_pkg::CFG_W'(last_bit[BW-1:IW]) >= eff_words;
  end

  // Masks and match bits of the word in hand
  always_comb begin
    data       = vld_rd ? ram_rdata : '0;
    lo_idx     = (addr == first_q[BW-1:IW]) ? first_q[IW-1:0] : '0;
    hi_idx     = (addr == last_word) ? last_q[IW-1:0] : '1;
    range_mask = ({WB{1'b1}} << lo_idx) & ({WB{1'b1}} >> (IW'(WB - 1) - hi_idx));
    bit_mask   = abe_pkg::word_t'(1) << first_q[IW-1:0];
    want       = (op == abe_pkg::ACT_FIND_SET) || (op == abe_pkg::ACT_RUN_SET);
    match_bits = (want ? data : ~data) & range_mask;
    hit_off_ext = (IW+1)'(scan_res.hit_idx) + (IW+1)'(1) - need_q[IW:0];
    tail_off   = '0 - scan_res.tail_ones;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      abe_pkg::S_IDLE: begin
        if (accept && go_exec) begin
          state_next = abe_pkg::S_EXEC;
        end
      end
      abe_pkg::S_EXEC: begin
        if (finish) begin
          state_next = abe_pkg::S_IDLE;
        end
      end
      default: state_next = abe_pkg::S_IDLE;
    endcase
  end

  // Decode, read-modify-write and result selection
  always_comb begin
    go_exec        = 1'b0;
    finish         = 1'b0;
    adv            = 1'b0;
    carry_upd      = 1'b0;
    res_load       = 1'b0;
    res_status     = abe_pkg::ST_OK;
    res_bit        = 1'b0;
    res_pos        = '0;
    ram_we         = 1'b0;
    ram_wdata      = data;
    ram_re         = 1'b0;
    ram_raddr      = addr + AW'(1);
    cnt_next       = cnt;
    start_pos_next = start_pos;
    unique case (state)
      abe_pkg::S_IDLE: begin
        ram_raddr = first_bit[BW-1:IW];
        if (accept) begin
          unique case (act_in) inside
            abe_pkg::ACT_SET_BIT, abe_pkg::ACT_CLR_BIT, abe_pkg::ACT_TEST: begin
              if (first_bad) begin
                res_status = abe_pkg::ST_RANGE;
              end else begin
                go_exec = 1'b1;
              end
            end
            abe_pkg::ACT_SET_RANGE, abe_pkg::ACT_CLR_RANGE: begin
              if (first_bad || last_bad) begin
                res_status = abe_pkg::ST_RANGE;
              end else if (first_bit <= last_bit) begin
                go_exec = 1'b1;
              end
            end
            abe_pkg::ACT_FIND_CLR, abe_pkg::ACT_FIND_SET: begin
              if (first_bad || last_bad) begin
                res_status = abe_pkg::ST_RANGE;
              end else if (first_bit > last_bit) begin
                res_status = abe_pkg::ST_NOTFOUND;
              end else begin
                go_exec = 1'b1;
              end
            end
            abe_pkg::ACT_RUN_CLR, abe_pkg::ACT_RUN_SET: begin
              if (first_bad || last_bad) begin
                res_status = abe_pkg::ST_RANGE;
              end else if (first_bit > last_bit || run_length == '0) begin
                res_status = abe_pkg::ST_NOTFOUND;
              end else begin
                go_exec = 1'b1;
              end
            end
            default: res_status = abe_pkg::ST_OK;
          endcase
          ram_re   = go_exec;
          res_load = !go_exec;
        end
      end
      abe_pkg::S_EXEC: begin
        unique case (op) inside
          abe_pkg::ACT_SET_BIT, abe_pkg::ACT_CLR_BIT: begin
            ram_we    = 1'b1;
            ram_wdata = (op == abe_pkg::ACT_SET_BIT) ? (data | bit_mask) : (data & ~bit_mask);
            finish    = 1'b1;
          end
          abe_pkg::ACT_TEST: begin
            res_bit = data[first_q[IW-1:0]];
            finish  = 1'b1;
          end
          abe_pkg::ACT_SET_RANGE, abe_pkg::ACT_CLR_RANGE: begin
            ram_we    = 1'b1;
            ram_wdata = (op == abe_pkg::ACT_SET_RANGE) ? (data | range_mask)
                                                       : (data & ~range_mask);
            if (addr == last_word) begin
              finish = 1'b1;
            end else begin
              adv = 1'b1;
            end
          end
          abe_pkg::ACT_FIND_CLR, abe_pkg::ACT_FIND_SET,
          abe_pkg::ACT_RUN_CLR, abe_pkg::ACT_RUN_SET: begin
            if (scan_res.hit) begin
              finish = 1'b1;
              if (scan_res.hit_cont && cnt != '0) begin
                res_pos = start_pos;
              end else begin
                res_pos = {addr, hit_off_ext[IW-1:0]};
              end
            end else if (addr == last_word) begin
              finish     = 1'b1;
              res_status = abe_pkg::ST_NOTFOUND;
            end else begin
              adv       = 1'b1;
              carry_upd = 1'b1;
              if (scan_res.all_ones) begin
                cnt_next       = cnt + abe_pkg::CNT_W'(WB);
                start_pos_next = (cnt == '0) ? {addr, IW'(0)} : start_pos;
              end else begin
                cnt_next       = abe_pkg::CNT_W'(scan_res.tail_ones);
                start_pos_next = {addr, tail_off};
              end
            end
          end
          default: finish = 1'b1;
        endcase
        ram_re   = adv;
        res_load = finish;
      end
      default: res_load = 1'b0;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= abe_pkg::S_IDLE;
      done         <= 1'b0;
      active_words <= abe_pkg::CFG_W'(abe_pkg::CFG_RESET);
      valid_bits   <= '0;
    end else begin
      state <= state_next;
      done  <= res_load;
      if (cfg_valid && cfg_ready) begin
        active_words <= cfg_data;
      end
      if (ram_we) begin
        valid_bits[ram_waddr] <= 1'b1;
      end
    end
  end

  // Item context, walk position and run carry
  always_ff @(posedge clk) begin
    if (accept && go_exec) begin
      op      <= act_in;
      first_q <= first_bit;
      last_q  <= last_bit;
      addr    <= first_bit[BW-1:IW];
      cnt     <= '0;
      if (act_in == abe_pkg::ACT_RUN_CLR || act_in == abe_pkg::ACT_RUN_SET) begin
        need_q <= run_length;
      end else begin
        need_q <= abe_pkg::RUN_W'(1);
      end
      if (act_in == abe_pkg::ACT_SET_BIT || act_in == abe_pkg::ACT_CLR_BIT ||
          act_in == abe_pkg::ACT_TEST) begin
        last_word <= first_bit[BW-1:IW];
      end else begin
        last_word <= last_bit[BW-1:IW];
      end
    end else begin
      if (adv) begin
        addr <= addr + AW'(1);
      end
      if (carry_upd) begin
        cnt       <= cnt_next;
        start_pos <= start_pos_next;
      end
    end
    if (ram_re) begin
      vld_rd <= valid_bits[ram_raddr];
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (res_load) begin
      status    <= res_status;
      bit_value <= res_bit;
      position  <= res_pos;
    end
  end

  // Assertions
  `ABE_ASSERT(a_no_rw_collide, ram_we && ram_re |-> ram_waddr != ram_raddr, "rw on one word")
  `ABE_ASSERT(a_done_when_idle, done |-> !busy, "result shown while still walking")
  `ABE_ASSERT(a_accept_progress, start && !busy |=> done || busy, "accepted transaction dropped")
  `ABE_ASSERT(a_fail, done && status != abe_pkg::ST_OK |-> {bit_value, position} == '0, "data")
  `ABE_ASSERT(a_walk_bound, busy |-> addr <= last_word, "walk ran past the last word")
  `ABE_ASSERT_NORST(a_reset_quiet, rst |=> !done && !busy, "activity right after reset")

endmodule
`default_nettype wire
